[rtl/core/arl_pkg.sv]
// ----------------------------------------------------------------------------
// Address range lookup package
// Shared widths, constants and types of the range table search.
// ----------------------------------------------------------------------------
package arl_pkg;

    localparam int ADDR_W    = 64;
    localparam int IDX_W     = 8;
    localparam int MAX_ENTRIES = 256;
    localparam int COUNT_W   = 9;
    // A window of MAX_ENTRIES entries needs COUNT_W halvings to close, so the
    // chain has one cell per count bit.
    localparam int LEVELS    = COUNT_W;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // State of one lookup as it travels from cell to cell.
    typedef struct packed {
        logic                valid;
        logic [ADDR_W-1:0]   address;
        logic [COUNT_W-1:0]  lo;
        logic [COUNT_W-1:0]  hi;
        logic [COUNT_W-1:0]  count;
    } search_t;

    // Table entry written from the top level into the cells.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
    } entry_t;

    // True when addr lies at or beyond base + size, with no wraparound.
    function automatic logic past_end(input logic [ADDR_W-1:0] addr,
                                      input logic [ADDR_W-1:0] base,
                                      input logic [ADDR_W-1:0] size);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, base} + {1'b0, size};
            past_end = ({1'b0, addr} >= sum);
        end
    endfunction

endpackage

[rtl/core/arl_cell.sv]
// ----------------------------------------------------------------------------
// Address range lookup search cell
// One bisection step: holds a copy of the table, probes the midpoint, narrows
// the window and hands it to the next cell.
// ----------------------------------------------------------------------------
module arl_cell (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [arl_pkg::IDX_W-1:0]         wr_index,
    input  arl_pkg::entry_t                   wr_entry,
    input  arl_pkg::search_t                  in_search,
    input  logic                              advance,
    output arl_pkg::search_t                  out_search
);

    // Each cell keeps its own table copy so all levels read in parallel.
    arl_pkg::entry_t mem [arl_pkg::MAX_ENTRIES];

    arl_pkg::search_t stage_reg;
    arl_pkg::entry_t  rd_reg;
    logic [arl_pkg::COUNT_W-1:0] mid;
    arl_pkg::search_t out_next;

    assign mid = in_search.lo + ((in_search.hi - in_search.lo) >> 1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index] <= wr_entry;
        end
        if (advance) begin
            rd_reg <= mem[mid[arl_pkg::IDX_W-1:0]];
        end
    end

    // The probe that stage_reg holds was at the midpoint of its window.
    always_comb begin
        logic [arl_pkg::COUNT_W-1:0] pm;
        pm = stage_reg.lo + ((stage_reg.hi - stage_reg.lo) >> 1);
        out_next = stage_reg;
        if (stage_reg.lo < stage_reg.hi) begin
            if (arl_pkg::past_end(stage_reg.address, rd_reg.base, rd_reg.size)) begin
                out_next.lo = pm + 1'b1;
            end else begin
                out_next.hi = pm;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= in_search.valid;
        end
        if (advance) begin
            stage_reg.address <= in_search.address;
            stage_reg.lo      <= in_search.lo;
            stage_reg.hi      <= in_search.hi;
            stage_reg.count   <= in_search.count;
        end
    end

    assign out_search = out_next;

endmodule

[rtl/core/arl_final.sv]
// ----------------------------------------------------------------------------
// Address range lookup final check
// Reads the entry the search settled on and decides whether it contains
// the address.
// ----------------------------------------------------------------------------
module arl_final (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [arl_pkg::IDX_W-1:0]    wr_index,
    input  arl_pkg::entry_t              wr_entry,
    input  arl_pkg::search_t             in_search,
    input  logic                         advance,
    output logic                         res_valid,
    output logic                         res_found,
    output logic [arl_pkg::IDX_W-1:0]    res_index
);

    arl_pkg::entry_t mem [arl_pkg::MAX_ENTRIES];
    arl_pkg::entry_t  rd_reg;
    arl_pkg::search_t stage_reg;
    logic [arl_pkg::ADDR_W-1:0] offset;
    logic hit;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_index] <= wr_entry;
        end
        if (advance) begin
            rd_reg <= mem[in_search.lo[arl_pkg::IDX_W-1:0]];
            stage_reg.address <= in_search.address;
            stage_reg.lo      <= in_search.lo;
            stage_reg.hi      <= in_search.hi;
            stage_reg.count   <= in_search.count;
        end
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (advance) begin
            stage_reg.valid <= in_search.valid;
        end
    end

    assign offset = stage_reg.address - rd_reg.base;
    assign hit = (stage_reg.lo < stage_reg.count)
              && (stage_reg.address >= rd_reg.base) && (offset < rd_reg.size);

    assign res_valid = stage_reg.valid;
    assign res_found = hit;
    assign res_index = hit ? stage_reg.lo[arl_pkg::IDX_W-1:0] : '0;

endmodule

[rtl/core/address_range_lookup.sv]
// ----------------------------------------------------------------------------
// Address range lookup
// Range table with a binary search carried out by a chain of bisection cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_axis    in         cmd (tuser), entry_index/entry_base/entry_size/address
//  m_axis    out        found, match_index
//  cfg       in         entry_count
//
//  A lookup passes nine bisection cells and the final check, each registered,
//  and then the result register, which drives m_axis_tvalid. One lookup is in
//  flight at a time: s_axis_tready stays low until the result transfer, so a
//  new lookup or write is taken only after the previous result has left, while
//  writes with no lookup in flight are taken back to back. The chain advances
//  only while its result slot is free or being taken, so a stalled m_axis holds
//  the result. Reset clears the chain and entry_count; the table contents are undefined until written.
// ----------------------------------------------------------------------------
module address_range_lookup (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] entry_index, [71:8] entry_base, [135:72] entry_size,
    // [199:136] address
    input  logic [199:0] s_axis_tdata,
    // [0] cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] found, [8:1] match_index, [15:9] zero
    output logic [15:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data
);

    logic [arl_pkg::COUNT_W-1:0] count_reg;
    logic                        busy_reg;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [arl_pkg::IDX_W-1:0]   out_index_reg;

    arl_pkg::search_t chain [arl_pkg::LEVELS+1];
    arl_pkg::entry_t  wr_entry;
    logic wr_en, lookup_acc, advance;
    logic res_valid, res_found;
    logic [arl_pkg::IDX_W-1:0] res_index;
    logic [arl_pkg::COUNT_W-1:0] sat_count;

    assign s_axis_tready = !busy_reg;
    assign cfg_ready     = 1'b1;
    assign wr_en      = s_axis_tvalid && s_axis_tready && (s_axis_tuser == arl_pkg::CMD_WRITE);
    assign lookup_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == arl_pkg::CMD_LOOKUP);
    assign wr_entry.base = s_axis_tdata[71:8];
    assign wr_entry.size = s_axis_tdata[135:72];
    assign advance = !out_valid_reg || m_axis_tready;

    assign sat_count = (count_reg > arl_pkg::COUNT_W'(arl_pkg::MAX_ENTRIES))
                     ? arl_pkg::COUNT_W'(arl_pkg::MAX_ENTRIES) : count_reg;

    assign chain[0].valid   = lookup_acc;
    assign chain[0].address = s_axis_tdata[199:136];
    assign chain[0].lo      = '0;
    assign chain[0].hi      = sat_count;
    assign chain[0].count   = sat_count;

    for (genvar g = 0; g < arl_pkg::LEVELS; g++) begin : g_cell
        arl_cell u_cell (
            .aclk(aclk), .aresetn(aresetn),
            .wr_en(wr_en), .wr_index(s_axis_tdata[7:0]), .wr_entry(wr_entry),
            .in_search(chain[g]), .advance(advance), .out_search(chain[g+1])
        );
    end

    arl_final u_final (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(wr_en), .wr_index(s_axis_tdata[7:0]), .wr_entry(wr_entry),
        .in_search(chain[arl_pkg::LEVELS]), .advance(advance),
        .res_valid(res_valid), .res_found(res_found), .res_index(res_index)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (lookup_acc) begin
                busy_reg <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                busy_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= res_valid;
            end
        end
        if (advance) begin
            out_found_reg <= res_found;
            out_index_reg <= res_index;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_index_reg, out_found_reg};

    // A result never appears without a lookup in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> busy_reg)
        else $error("result without a lookup in flight");

    // A not-found result carries index zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[8:1] == '0))
        else $error("nonzero index on a miss");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Address range lookup testbench
// Loads sorted range tables, sweeps the entry count through its extremes and
// checks every lookup result against a bit-accurate binary search predictor.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       found;
        logic [7:0] index;
    } lookup_hit_t;

    class range_scoreboard;
        logic [63:0] bases [256];
        logic [63:0] sizes [256];
        logic [8:0]  entry_count;
        lookup_hit_t hits_q [$];
        int          errors;

        function new();
            entry_count = '0;
            errors = 0;
        endfunction

        // Mirrors the search: first entry whose end lies above the address.
        function lookup_hit_t search(logic [63:0] addr);
            lookup_hit_t h;
            int          lo;
            int          hi;
            int          mid;
            int          cnt;
            logic [64:0] sum;
            cnt = (entry_count > 256) ? 256 : entry_count;
            lo = 0;
            hi = cnt;
            h.found = 1'b0;
            h.index = '0;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                sum = {1'b0, bases[mid]} + {1'b0, sizes[mid]};
                if ({1'b0, addr} >= sum) lo = mid + 1;
                else hi = mid;
            end
            if (lo < cnt && addr >= bases[lo] && (addr - bases[lo]) < sizes[lo]) begin
                h.found = 1'b1;
                h.index = lo[7:0];
            end
            return h;
        endfunction

        function void note_item(logic cmd, logic [199:0] d);
            if (cmd == arl_pkg::CMD_WRITE) begin
                bases[d[7:0]] = d[71:8];
                sizes[d[7:0]] = d[135:72];
            end else begin
                hits_q.push_back(search(d[199:136]));
            end
        endfunction

        function void check_result(logic [15:0] r);
            lookup_hit_t h;
            if (hits_q.size() == 0) begin
                $display("%0t: unexpected result found=%0d index=%0d", $time, r[0], r[8:1]);
                errors++;
                return;
            end
            h = hits_q.pop_front();
            if (r[0] !== h.found) begin
                $display("%0t: found expected %0d actual %0d", $time, h.found, r[0]);
                errors++;
            end
            if (r[8:1] !== h.index) begin
                $display("%0t: match_index expected %0d actual %0d", $time, h.index, r[8:1]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;   // [7:0] index, [71:8] base, [135:72] size, [199:136] address
    logic         s_axis_tuser;   // [0] cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;   // [0] found, [8:1] match_index, [15:9] zero
    logic         cfg_valid;
    logic         cfg_ready;
    logic [8:0]   cfg_data;

    range_scoreboard ranges = new();
    bit              steady;

    address_range_lookup u_dut (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Transfers are observed before the edge's own updates take effect.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) ranges.note_item(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) ranges.check_result(m_axis_tdata);
            if (cfg_valid && cfg_ready) ranges.entry_count = cfg_data;
        end
    end

    // Result side backpressure in random bursts.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            if (!steady && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(logic cmd, logic [7:0] idx, logic [63:0] base,
                        logic [63:0] size, logic [63:0] addr);
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {addr, size, base, idx};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic lookup(logic [63:0] addr);
        send(arl_pkg::CMD_LOOKUP, 8'(rand64()), rand64(), rand64(), addr);
    endtask

    task automatic write_range(logic [7:0] idx, logic [63:0] base, logic [63:0] size);
        send(arl_pkg::CMD_WRITE, idx, base, size, rand64());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (ranges.hits_q.size() != 0);
        // A trailing write leaves no result to wait for.
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_count(logic [8:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Each slot keeps its own 2^56 region, so rewrites keep the table sorted.
    function automatic logic [63:0] region_base(int i);
        return {i[7:0], 56'd0} + {8'd0, rand64() >> 9};
    endfunction

    function automatic logic [63:0] region_size(int i);
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            default: return rand64() >> ($urandom_range(9, 63));
        endcase
    endfunction

    // Address aimed at the edges of a table entry, or anywhere.
    function automatic logic [63:0] pick_address();
        int          k;
        logic [63:0] b;
        logic [63:0] s;
        k = $urandom_range(0, 255);
        b = ranges.bases[k];
        s = ranges.sizes[k];
        case ($urandom_range(0, 7))
            0: return b;
            1: return b - 1;
            2: return b + s;
            3: return b + s - 1;
            4, 5: return (s == 0) ? b : b + (rand64() % s);
            default: return rand64();
        endcase
    endfunction

    task automatic load_table();
        for (int i = 0; i < 256; i++) begin
            if (i == 255) write_range(8'(i), 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF);
            else if (i == 5) write_range(8'(i), region_base(i), 64'd0);
            else write_range(8'(i), region_base(i), region_size(i));
        end
    endtask

    initial begin
        int   k;
        logic [8:0] cnt;
        steady        = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: nothing can be found.
        lookup(64'd0);
        lookup(64'hFFFF_FFFF_FFFF_FFFF);
        lookup(rand64());
        load_table();

        set_count(9'd256);
        lookup(64'd0);
        lookup(64'hFFFF_FFFF_FFFF_FFFF);
        lookup(ranges.bases[0]);
        lookup(ranges.bases[5]);                  // zero-size range
        lookup(ranges.bases[100] - 1);
        lookup(ranges.bases[100] + ranges.sizes[100]);
        lookup(ranges.bases[255]);                // end beyond 2^64 - 1
        set_count(9'd1);
        lookup(ranges.bases[0]);
        lookup(ranges.bases[1]);
        set_count(9'd511);                        // saturates to the table size
        lookup(64'hFFFF_FFFF_FFFF_FFFE);
        lookup(ranges.bases[128]);
        set_count(9'd257);
        lookup(ranges.bases[200]);
        set_count(9'd0);
        lookup(ranges.bases[0]);

        for (int phase = 0; phase < 20; phase++) begin
            case (phase % 5)
                0: cnt = 9'd256;
                1: cnt = 9'($urandom_range(1, 8));
                2: cnt = 9'($urandom_range(0, 511));
                3: cnt = 9'($urandom_range(200, 300));
                default: cnt = 9'($urandom_range(0, 256));
            endcase
            if (phase == 16) steady = 1'b1;
            set_count(cnt);
            for (int n = 0; n < 45; n++) begin
                k = $urandom_range(0, 99);
                if (k < 8) begin
                    k = $urandom_range(0, 255);
                    write_range(8'(k), region_base(k), region_size(k));
                end else if (k < 10) begin
                    // Arbitrary content may leave the table unsorted.
                    write_range(8'($urandom_range(0, 255)), rand64(), rand64());
                end else begin
                    lookup(pick_address());
                end
            end
        end

        drain();
        if (ranges.errors == 0 && ranges.hits_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
